/* src/ple_pkg.sv */
// Package for the positional list engine.
// Holds the op and status codes, the request and response payload types,
// and the shift command type that goes to the cell row. No dependencies.
package ple_pkg;

   // Default number of cells in the list.
   localparam int CAPACITY_DEF = 16;

   // Field widths fixed by the request and response formats.
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Request op codes.
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] removed_value;
      logic signed [VALUE_W-1:0] head_value;
   } rsp_payload_type;

   // Shift command broadcast to every cell for one request.
   typedef struct packed {
      logic ins;   // open a slot at the target index
      logic del;   // close the slot at the target index
   } shift_type;

endpackage

/* src/ple_chan_if.sv */
// Valid/ready channel interface used for the request and response sides.
// Depends on ple_pkg only through the payload type handed in.
interface ple_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/ple_cell.sv */
// One storage cell of the list: holds one value and shifts with its neighbors.
// Depends on ple_pkg for the shift command type and the value width.
module ple_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 5
) (
   input  logic                          clock,
   input  ple_pkg::shift_type            shift,
   input  logic [IDX_W-1:0]              target_idx,
   input  logic signed [ple_pkg::VALUE_W-1:0] new_value,
   input  logic signed [ple_pkg::VALUE_W-1:0] left_value,
   input  logic signed [ple_pkg::VALUE_W-1:0] right_value,
   output logic signed [ple_pkg::VALUE_W-1:0] data,
   output logic signed [ple_pkg::VALUE_W-1:0] data_next,
   output logic signed [ple_pkg::VALUE_W-1:0] pick
);
   import ple_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;
   logic                      at_target;
   logic                      past_target;

   assign at_target   = (target_idx == MY_IDX);
   assign past_target = (MY_IDX > target_idx);

   // Cells behind the target move back on an insert; cells at or behind it
   // move forward on a delete.
   always_comb begin
      data_in = data_ff;
      if (shift.ins) begin
         if (at_target) begin
            data_in = new_value;
         end else if (past_target) begin
            data_in = left_value;
         end
      end else if (shift.del && (at_target || past_target)) begin
         data_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // The deleted value leaves through this port; other cells give zero.
   assign pick      = (shift.del && at_target) ? data_ff : '0;
   assign data      = data_ff;
   assign data_next = data_in;

endmodule

/* src/positional_list_engine.sv */
// Top level of the positional list engine: request decode, occupancy count,
// the row of ple_cell instances and the response register.
// Depends on ple_pkg, ple_chan_if and ple_cell.
//
//   Channel  Dir  Payload                                      Handshake
//   req      in   op, value, position                          valid/ready
//   rsp      out  status, count, removed_value, head_value     valid/ready
//
// Every request is decoded, applied to all cells and registered as a response
// at the edge that accepts it, so one request is taken per cycle unless a response is stalled on the rsp side.
// Each cell compares its own index with the target and loads from a neighbor.
// Synchronous reset empties the list and drops any pending response.
// A response waiting on a stalled rsp side blocks the next request only while
// rsp.ready is low.
module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input logic       clock,
   input logic       reset,
   ple_chan_if.sink   req,
   ple_chan_if.source rsp
);
   import ple_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

   logic [CW-1:0]       occ_ff;
   logic [CW-1:0]       occ_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_payload_type     rsp_data_ff;
   rsp_payload_type     rsp_data_in;

   logic                accept;
   logic [PW-1:0]       occ_w;
   logic [PW-1:0]       pos_w;
   logic [PW-1:0]       occ_next_w;
   logic [STATUS_W-1:0] status;
   logic                do_ins;
   logic                do_del;
   logic [CW-1:0]       target_idx;
   shift_type           shift;

   logic signed [VALUE_W-1:0] cell_q    [CAPACITY];
   logic signed [VALUE_W-1:0] cell_next [CAPACITY];
   logic signed [VALUE_W-1:0] cell_pick [CAPACITY];
   logic signed [VALUE_W-1:0] removed;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign occ_w = PW'(occ_ff);
   assign pos_w = PW'(req.payload.position);

   // Request decode: status, kind of shift and the target cell index.
   always_comb begin
      status     = ST_OK;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      target_idx = '0;
      unique case (req.payload.op) inside
         OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (occ_w >= CAP_W) begin
               status = ST_FULL;
            end else if (req.payload.op == OP_INS_FRONT) begin
               do_ins = 1'b1;
            end else if (req.payload.op == OP_INS_BACK) begin
               do_ins     = 1'b1;
               target_idx = occ_ff;
            end else if (pos_w == '0 || pos_w > occ_w + PW'(1)) begin
               status = ST_BADPOS;
            end else begin
               do_ins     = 1'b1;
               target_idx = CW'(pos_w - PW'(1));
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
            if (occ_w == '0) begin
               status = ST_EMPTY;
            end else if (req.payload.op == OP_DEL_FRONT) begin
               do_del = 1'b1;
            end else if (req.payload.op == OP_DEL_BACK) begin
               do_del     = 1'b1;
               target_idx = occ_ff - CW'(1);
            end else if (pos_w == '0 || pos_w > occ_w) begin
               status = ST_BADPOS;
            end else begin
               do_del     = 1'b1;
               target_idx = CW'(pos_w - PW'(1));
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign shift.ins = accept && do_ins;
   assign shift.del = accept && do_del;

   // Row of cells; the ends see the new value and zero as outside neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ple_cell #(
         .INDEX (i),
         .IDX_W (CW)
      ) u_cell (
         .clock       (clock),
         .shift       (shift),
         .target_idx  (target_idx),
         .new_value   (req.payload.value),
         .left_value  ((i == 0) ? req.payload.value : cell_q[(i == 0) ? 0 : i - 1]),
         .right_value ((i == CAPACITY - 1) ? '0
                        : cell_q[(i == CAPACITY - 1) ? i : i + 1]),
         .data        (cell_q[i]),
         .data_next   (cell_next[i]),
         .pick        (cell_pick[i])
      );
   end

   // Only the target cell drives a nonzero pick, so an OR collects it.
   always_comb begin
      removed = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         removed = removed | cell_pick[i];
      end
   end

   // Occupancy after the request.
   always_comb begin
      occ_in = occ_ff;
      if (shift.ins) begin
         occ_in = occ_ff + CW'(1);
      end else if (shift.del) begin
         occ_in = occ_ff - CW'(1);
      end
   end

   assign occ_next_w = PW'(occ_in);

   // Response register: loads on accept, clears when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = status;
         rsp_data_in.count         = occ_next_w[COUNT_W-1:0];
         rsp_data_in.removed_value = removed;
         rsp_data_in.head_value    = (occ_in == '0) ? '0 : cell_next[0];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule
